>>> hw/rtl/sha256_message_digest_core_defines.svh
// Assertion macros for the SHA-256 core RTL, used by sha_ctrl.
// Depends on a clk and an arst_n signal in the module that expands them.
`ifndef SHA256_MESSAGE_DIGEST_CORE_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_CORE_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define SHA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define SHA_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/sha_pkg.sv
// Types, constants and helper functions for the SHA-256 core.
// Used by the controller, the datapath and the top level.
package sha_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} sha_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
		logic        length_error;
	} sha_out_t;

	typedef enum logic [1:0] {
		SRC_IN,
		SRC_PAD,
		SRC_ZERO,
		SRC_LEN
	} sha_src_t;

	typedef struct packed {
		logic       insert;
		sha_src_t   src;
		logic [2:0] len_idx;
		logic       count;
		logic       round;
		logic [5:0] rnd;
		logic       hash_add;
		logic       restart;
		logic [2:0] out_idx;
	} sha_cmd_t;

	typedef struct packed {
		logic fill_last;
		logic fill56;
		logic ovf;
	} sha_status_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] FILL_LEN_POS = 6'd56;

	localparam logic [31:0] H0 [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

>>> hw/rtl/sha256_message_digest_core.sv
// Top level of the SHA-256 message digest core.
// Joins sha_ctrl and sha_dpath; depends on sha_pkg.
//
//   channel  | valid     | stall     | payload
//   ---------+-----------+-----------+---------------------------
//   message  | msg_valid | msg_stall | msg (data byte, present, end)
//   digest   | dig_valid | dig_stall | dig (word, index, last, error)
//
// A message byte is taken while the core is idle. The 64th byte of a block
// starts the compression: the rounds in S_ROUND, then the hash update.
// An end item adds 9 to 72 pad bytes and one or two compressions, then eight
// digest transfers (a length error: no pad, one transfer); msg_stall stays high.
// Reset loads the initial hash and clears the length and fill counts.
module sha256_message_digest_core
	import sha_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     msg_valid,
	output logic     msg_stall,
	input  sha_in_t  msg,
	output logic     dig_valid,
	input  logic     dig_stall,
	output sha_out_t dig
);

	sha_cmd_t    cmd;
	sha_status_t status;
	logic [31:0] hash_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg_valid),
		.msg_stall      (msg_stall),
		.byte_present   (msg.byte_present),
		.end_of_message (msg.end_of_message),
		.dig_valid      (dig_valid),
		.dig_stall      (dig_stall),
		.word_index     (word_index),
		.last_word      (last_word),
		.cmd            (cmd),
		.status         (status)
	);

	sha_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (msg.data_byte),
		.cmd       (cmd),
		.status    (status),
		.hash_word (hash_word)
	);

	assign dig.digest_word  = status.ovf ? 32'd0 : hash_word;
	assign dig.word_index   = word_index;
	assign dig.last_word    = last_word;
	assign dig.length_error = status.ovf;

endmodule

>>> hw/rtl/sha_dpath.sv
// Datapath of the SHA-256 core: block shift line, length counter,
// message schedule, round logic and hash words. Depends on sha_pkg.
module sha_dpath
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  sha_cmd_t    cmd,
	output sha_status_t status,
	output logic [31:0] hash_word
);

	logic [5:0]   fill_q;
	logic [60:0]  len_q;
	logic         ovf_q;
	logic [511:0] blk_q;
	logic [31:0]  w_q [16];
	logic [31:0]  v_q [8];
	logic [31:0]  hash_q [8];

	logic [63:0]  len_bits;
	logic [7:0]   len_byte;
	logic [7:0]   ins_byte;
	logic [511:0] blk_next;
	logic [31:0]  w_new;
	logic [31:0]  t1;
	logic [31:0]  t2;

	always_comb begin
		len_bits = {len_q, 3'b000};
		len_byte = 8'(len_bits >> {3'd7 - cmd.len_idx, 3'b000});
		case (cmd.src)
			SRC_IN:   ins_byte = data_byte;
			SRC_PAD:  ins_byte = PAD_BYTE;
			SRC_ZERO: ins_byte = 8'h00;
			SRC_LEN:  ins_byte = len_byte;
			default:  ins_byte = 8'h00;
		endcase
		blk_next = {blk_q[503:0], ins_byte};
		w_new = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
		t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ ROUND_K[cmd.rnd] + w_q[0];
		t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			ovf_q  <= 1'b0;
			hash_q <= H0;
		end else if (cmd.restart) begin
			fill_q <= '0;
			len_q  <= '0;
			ovf_q  <= 1'b0;
			hash_q <= H0;
		end else begin
			if (cmd.insert) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.count) begin
				if (len_q == '1) begin
					ovf_q <= 1'b1;
				end else begin
					len_q <= len_q + 61'd1;
				end
			end
			if (cmd.hash_add) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + v_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			blk_q <= blk_next;
			if (fill_q == '1) begin
				for (int i = 0; i < 16; i++) begin
					w_q[i] <= blk_next[511 - 32 * i -: 32];
				end
				v_q <= hash_q;
			end
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign status.fill_last = (fill_q == '1);
	assign status.fill56    = (fill_q == FILL_LEN_POS);
	assign status.ovf       = ovf_q;
	assign hash_word        = hash_q[cmd.out_idx];

endmodule

>>> hw/rtl/sha_ctrl.sv
// Controller of the SHA-256 core: byte intake, round sequencing,
// padding and digest output. Depends on sha_pkg and the defines header.
`include "sha256_message_digest_core_defines.svh"

module sha_ctrl
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_stall,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        dig_valid,
	input  logic        dig_stall,
	output logic [2:0]  word_index,
	output logic        last_word,
	output sha_cmd_t    cmd,
	input  sha_status_t status
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ROUND = 5'b00010,
		S_FINAL = 5'b00100,
		S_PAD   = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t     state_q;
	state_t     state_d;
	logic [5:0] rnd_q;
	logic       end_q;
	logic       sent80_q;
	logic [3:0] len_cnt_q;
	logic [2:0] widx_q;
	logic       out_xfer;

	assign msg_stall  = (state_q != S_IDLE);
	assign dig_valid  = (state_q == S_OUT);
	assign out_xfer   = dig_valid && !dig_stall;
	assign word_index = status.ovf ? 3'd0 : widx_q;
	assign last_word  = status.ovf || (widx_q == 3'd7);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.src = SRC_IN;
		cmd.len_idx = len_cnt_q[2:0];
		cmd.rnd = rnd_q;
		cmd.out_idx = widx_q;
		unique case (state_q)
			S_IDLE: begin
				if (msg_valid) begin
					if (byte_present) begin
						cmd.insert = 1'b1;
						cmd.count = 1'b1;
					end
					if (byte_present && status.fill_last) begin
						state_d = S_ROUND;
					end else if (end_of_message) begin
						state_d = S_PAD;
					end
				end
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				if (rnd_q == '1) begin
					state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				cmd.hash_add = 1'b1;
				if (!end_q) begin
					state_d = S_IDLE;
				end else if (len_cnt_q[3]) begin
					state_d = S_OUT;
				end else begin
					state_d = S_PAD;
				end
			end
			S_PAD: begin
				if (!sent80_q && status.ovf) begin
					state_d = S_OUT;
				end else begin
					cmd.insert = 1'b1;
					if (!sent80_q) begin
						cmd.src = SRC_PAD;
					end else if (len_cnt_q == 4'd0 && !status.fill56) begin
						cmd.src = SRC_ZERO;
					end else begin
						cmd.src = SRC_LEN;
					end
					if (status.fill_last) begin
						state_d = S_ROUND;
					end
				end
			end
			S_OUT: begin
				if (out_xfer && last_word) begin
					cmd.restart = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rnd_q     <= '0;
			end_q     <= 1'b0;
			sent80_q  <= 1'b0;
			len_cnt_q <= '0;
			widx_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.round) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (state_q == S_IDLE && msg_valid && end_of_message) begin
				end_q <= 1'b1;
			end
			if (cmd.insert && cmd.src == SRC_PAD) begin
				sent80_q <= 1'b1;
			end
			if (cmd.insert && cmd.src == SRC_LEN) begin
				len_cnt_q <= len_cnt_q + 4'd1;
			end
			if (out_xfer) begin
				widx_q <= widx_q + 3'd1;
			end
			if (cmd.restart) begin
				end_q     <= 1'b0;
				sent80_q  <= 1'b0;
				len_cnt_q <= '0;
				widx_q    <= '0;
			end
		end
	end

	`SHA_ASSERT_NEXT(a_round_end, state_q == S_ROUND && rnd_q == '1, state_q == S_FINAL,
		"last round not followed by hash update")
	`SHA_ASSERT(a_pad_has_end, state_q == S_PAD |-> end_q, "padding without end of message")
	`SHA_ASSERT_NEXT(a_last_to_idle, out_xfer && last_word, state_q == S_IDLE && widx_q == 3'd0,
		"final digest transfer did not restart")

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for sha256_message_digest_core: streams byte messages,
// predicts each digest in the testbench and compares every digest transfer.
// Depends on sha_pkg and the core RTL.
module tb_top;
	import sha_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		sha_in_t payload;
		bit      drain_first;
	} msg_item_t;

	logic     clk;
	logic     arst_n;
	logic     msg_valid;
	logic     msg_stall;
	sha_in_t  msg;
	logic     dig_valid;
	logic     dig_stall;
	sha_out_t dig;

	msg_item_t pending_items[$];
	sha_out_t  expected_digest[$];

	logic [31:0] model_hash [8];
	logic [7:0]  model_block [64];
	logic [5:0]  model_fill;
	logic [63:0] model_length;
	logic        model_ovf;

	logic [31:0] iv_words [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	int  errors = 0;
	int  cycles = 0;
	int  messages_done = 0;
	int  words_checked = 0;
	int  gap_left = 0;
	int  burst_left = 0;
	int  stall_mode = 0;
	int  stall_mode_left = 0;
	bit  msg_fire = 1'b0;
	bit  stimulus_done = 1'b0;

	sha256_message_digest_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.msg_valid(msg_valid),
		.msg_stall(msg_stall),
		.msg(msg),
		.dig_valid(dig_valid),
		.dig_stall(dig_stall),
		.dig(dig)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] sched [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			sched[i] = {model_block[4*i], model_block[4*i+1], model_block[4*i+2],
				model_block[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
			s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
			sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
		end
		a = model_hash[0]; b = model_hash[1]; c = model_hash[2]; d = model_hash[3];
		e = model_hash[4]; f = model_hash[5]; g = model_hash[6]; h = model_hash[7];
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_K[i] + sched[i];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		model_hash[0] += a; model_hash[1] += b; model_hash[2] += c; model_hash[3] += d;
		model_hash[4] += e; model_hash[5] += f; model_hash[6] += g; model_hash[7] += h;
	endtask

	task automatic restart_message();
		model_hash = iv_words;
		model_fill = '0;
		model_length = '0;
		model_ovf = 1'b0;
	endtask

	task automatic absorb_item(input sha_in_t item);
		logic [63:0] bit_count;
		int p;
		sha_out_t word;
		if (item.byte_present) begin
			if (model_length >= 64'h1fff_ffff_ffff_ffff)
				model_ovf = 1'b1;
			else
				model_length++;
			model_block[model_fill] = item.data_byte;
			model_fill++;
			if (model_fill == 0)
				compress_block();
		end
		if (!item.end_of_message)
			return;
		if (model_ovf) begin
			word.digest_word = '0;
			word.word_index = '0;
			word.last_word = 1'b1;
			word.length_error = 1'b1;
			expected_digest = {expected_digest, word};
			restart_message();
			return;
		end
		bit_count = model_length << 3;
		p = model_fill;
		model_block[p++] = PAD_BYTE;
		if (p > 56) begin
			while (p < 64)
				model_block[p++] = 8'h00;
			compress_block();
			p = 0;
		end
		while (p < 56)
			model_block[p++] = 8'h00;
		for (int i = 0; i < 8; i++)
			model_block[56+i] = bit_count[63-8*i -: 8];
		compress_block();
		for (int i = 0; i < 8; i++) begin
			word.digest_word = model_hash[i];
			word.word_index = 3'(i);
			word.last_word = (i == 7);
			word.length_error = 1'b0;
			expected_digest = {expected_digest, word};
		end
		restart_message();
	endtask

	// A message of len bytes, with optional idle items mixed in. The end
	// rides on the last byte or comes as a separate item without a byte.
	task automatic queue_message(input int len, input bit end_on_byte, input int noise,
			input bit drain);
		msg_item_t it;
		int left_noise;
		left_noise = noise;
		it.drain_first = drain;
		for (int i = 0; i < len; i++) begin
			if (left_noise > 0 && $urandom_range(0, 3) == 0) begin
				it.payload = '{data_byte: 8'($urandom_range(0, 255)), byte_present: 1'b0,
					end_of_message: 1'b0};
				pending_items = {pending_items, it};
				it.drain_first = 1'b0;
				left_noise--;
			end
			it.payload.data_byte = 8'($urandom_range(0, 255));
			it.payload.byte_present = 1'b1;
			it.payload.end_of_message = end_on_byte && (i == len - 1);
			pending_items = {pending_items, it};
			it.drain_first = 1'b0;
		end
		if (!end_on_byte || len == 0) begin
			it.payload = '{data_byte: 8'($urandom_range(0, 255)), byte_present: 1'b0,
				end_of_message: 1'b1};
			pending_items = {pending_items, it};
		end
	endtask

	// Sender: presents items at the falling edge in bursts separated by gaps.
	always @(negedge clk) begin
		if (arst_n && (!msg_valid || msg_fire)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				msg_valid <= 1'b0;
			end else if (pending_items.size() > 0 &&
					!(pending_items[0].drain_first && expected_digest.size() > 0)) begin
				msg <= pending_items[0].payload;
				pending_items.pop_front();
				msg_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				msg_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall pattern switches among free flow, random and long holds.
	always @(negedge clk) begin
		if (stall_mode_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_mode_left <= $urandom_range(5, 60);
		end else begin
			stall_mode_left <= stall_mode_left - 1;
		end
		case (stall_mode)
			0: dig_stall <= 1'b0;
			1: dig_stall <= $urandom_range(0, 1);
			default: dig_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("TB_ERROR");
			$finish;
		end
		msg_fire <= msg_valid && !msg_stall && arst_n;
		if (arst_n && msg_valid && !msg_stall)
			absorb_item(msg);
		if (arst_n && dig_valid && !dig_stall) begin
			if (expected_digest.size() == 0) begin
				errors++;
				$display("%0t: unexpected digest transfer expected none actual %h",
					$time, dig);
			end else begin
				if (dig !== expected_digest[0]) begin
					errors++;
					$display("%0t: digest mismatch expected %h actual %h",
						$time, expected_digest[0], dig);
				end
				if (expected_digest[0].last_word)
					messages_done++;
				words_checked++;
				expected_digest.pop_front();
			end
		end
	end

	initial begin
		int counted;
		int len;
		int pick;
		arst_n = 1'b0;
		msg_valid = 1'b0;
		msg = '0;
		dig_stall = 1'b0;
		restart_message();

		queue_message(0, 1'b0, 0, 1'b0);
		queue_message(1, 1'b1, 0, 1'b0);
		pending_items[$].payload.data_byte = 8'hff;
		queue_message(1, 1'b0, 0, 1'b0);
		pending_items[$-1].payload.data_byte = 8'h00;
		queue_message(3, 1'b1, 2, 1'b1);
		queue_message(6, 1'b0, 3, 1'b0);

		counted = 0;
		while (counted < 370) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: len = 55;
				1: len = 56;
				2: len = $urandom_range(57, 63);
				3: len = 64;
				4: len = $urandom_range(65, 130);
				default: len = $urandom_range(0, 40);
			endcase
			queue_message(len, $urandom_range(0, 1), $urandom_range(0, 3),
				$urandom_range(0, 3) == 0);
			counted += len + 1;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_items.size() == 0 && !msg_valid && expected_digest.size() == 0);
		repeat (300) @(posedge clk);
		$display("Checked %0d digest words over %0d messages (empty, block-boundary",
			words_checked, messages_done);
		$display("and multi-block lengths) under random source gaps and sink stalls.");
		if (errors == 0 && expected_digest.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/sha_pkg.sv
hw/rtl/sha_dpath.sv
hw/rtl/sha_ctrl.sv
hw/rtl/sha256_message_digest_core.sv
sim/tb_top.sv
